// ----- hdl/hbr_pkg.sv -----
// Shared types and constants for the task heartbeat registry.
// Used by every module of the block; depends on nothing else.
package hbr_pkg;

   // Table size and the widths that follow from it.
   localparam int TASK_SLOTS = 16;
   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

   // Command codes carried in the func field.
   localparam logic [2:0] FN_REGISTER = 3'd0;
   localparam logic [2:0] FN_FEED     = 3'd1;
   localparam logic [2:0] FN_FAULT    = 3'd2;
   localparam logic [2:0] FN_QUERY    = 3'd3;
   localparam logic [2:0] FN_CLEAR    = 3'd4;

   // Result codes.
   localparam logic [1:0] RC_OK        = 2'd0;
   localparam logic [1:0] RC_PARAM     = 2'd1;
   localparam logic [1:0] RC_FULL      = 2'd2;
   localparam logic [1:0] RC_NOT_FOUND = 2'd3;

   // Highest legal fault severity.
   localparam logic [2:0] LVL_FATAL = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // One task entry as held in the slot memory.
   typedef struct packed {
      logic [31:0] id;
      logic [31:0] tmo;
      logic [31:0] feeds;
   } slot_type;

   // Read and write request toward the slot memory.
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      slot_type          wr_data;
   } mem_req_type;

   // Control toward the fault summary.
   typedef struct packed {
      logic clear;
      logic update;
   } sum_ctl_type;

   // Fault summary contents.
   typedef struct packed {
      logic [31:0]        total;
      logic [1:0]         peak;
      logic               fatal;
      logic [7:0]         kind;
      logic signed [31:0] err;
   } fault_sum_type;

   // Per-command result from the sequencer.
   typedef struct packed {
      logic [1:0]  rc;
      logic [31:0] feeds;
      logic [31:0] tmo;
   } res_type;

endpackage

// ----- hdl/hbr_slot_ram.sv -----
// Slot memory of the heartbeat registry: id, timeout and feed count per slot.
// One write port and one read port with registered read data; uses hbr_pkg.
module hbr_slot_ram
   import hbr_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output slot_type    mem_rdata
);

   slot_type slot_mem [TASK_SLOTS];
   slot_type rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Read port, with registered read data.
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rdata_ff <= slot_mem[mem_req.rd_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ----- hdl/hbr_fault_sum.sv -----
// Fault summary registers: count, last kind and error, peak level, fatal flag.
// Driven by the command sequencer through sum_ctl_type; uses hbr_pkg.
module hbr_fault_sum
   import hbr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  sum_ctl_type        sum_ctl,
   input  logic [7:0]         fault_kind,
   input  logic [2:0]         fault_level,
   input  logic signed [31:0] err_value,
   output fault_sum_type      fault_sum
);

   fault_sum_type sum_ff;
   fault_sum_type sum_in;

   // Next summary: clear wins, otherwise fold in an accepted report.
   always_comb begin
      sum_in = sum_ff;
      if (sum_ctl.clear) begin
         sum_in = '0;
      end else if (sum_ctl.update) begin
         sum_in.total = sum_ff.total + 32'd1;
         sum_in.kind  = fault_kind;
         sum_in.err   = err_value;
         if (fault_level[1:0] > sum_ff.peak) begin
            sum_in.peak = fault_level[1:0];
         end
         if (fault_level == LVL_FATAL) begin
            sum_in.fatal = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   assign fault_sum = sum_ff;

endmodule

// ----- hdl/hbr_ctrl.sv -----
// Command sequencer: decodes a word, scans the slot memory one entry per
// cycle, and writes back the updated entry. Holds the valid bits; uses hbr_pkg.
module hbr_ctrl
   import hbr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [2:0]       req_func,
   input  logic [31:0]      req_task_id,
   input  logic [31:0]      req_timeout_limit,
   input  logic [7:0]       req_fault_kind,
   input  logic [2:0]       req_fault_level,
   input  logic             out_free,
   output logic             done,
   output res_type          result,
   output logic [CNT_W-1:0] slots_used,
   output sum_ctl_type      sum_ctl,
   output mem_req_type      mem_req,
   input  slot_type         mem_rdata
);

   state_type         state_ff, state_in;
   logic [2:0]        cmd_func_ff, cmd_func_in;
   logic [31:0]       cmd_id_ff, cmd_id_in;
   logic [31:0]       cmd_tmo_ff, cmd_tmo_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_idx_ff, pend_idx_in;
   logic              free_found_ff, free_found_in;
   logic [SLOT_W-1:0] free_idx_ff, free_idx_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   res_type           res_ff, res_in;

   logic              fault_ok;
   logic              hit;
   logic              pend_free;
   logic              free_any;
   logic [SLOT_W-1:0] free_idx;
   logic              scan_end;

   // Compare stage: the entry read last cycle against the command's id, and
   // the lowest free slot seen so far.
   always_comb begin
      fault_ok  = (req_fault_kind != 8'd0) && (req_fault_level != 3'd0) &&
                  (req_fault_level <= LVL_FATAL);
      hit       = pend_ff && valid_ff[pend_idx_ff] && (mem_rdata.id == cmd_id_ff);
      pend_free = pend_ff && !valid_ff[pend_idx_ff];
      free_any  = free_found_ff || pend_free;
      free_idx  = free_found_ff ? free_idx_ff : pend_idx_ff;
      scan_end  = (scan_ff == CNT_W'(TASK_SLOTS));
   end

   // Next state and outputs. All memory writes happen in the last scan cycle
   // and the next word is not taken before the result leaves, so a read never
   // overlaps a pending write to the same entry.
   always_comb begin
      state_in      = state_ff;
      cmd_func_in   = cmd_func_ff;
      cmd_id_in     = cmd_id_ff;
      cmd_tmo_in    = cmd_tmo_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      free_found_in = free_any;
      free_idx_in   = free_idx;
      valid_in      = valid_ff;
      used_in       = used_ff;
      res_in        = res_ff;
      mem_req       = '0;
      sum_ctl       = '0;
      req_stall     = (state_ff != ST_IDLE);
      done          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_func_in   = req_func;
               cmd_id_in     = req_task_id;
               cmd_tmo_in    = req_timeout_limit;
               scan_in       = '0;
               free_found_in = 1'b0;
               res_in        = '0;
               state_in      = ST_FINISH;
               unique case (req_func) inside
                  FN_REGISTER: begin
                     if (req_task_id == 32'd0 || req_timeout_limit == 32'd0) begin
                        res_in.rc = RC_PARAM;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FN_FEED, FN_QUERY: begin
                     state_in = ST_SCAN;
                  end
                  FN_FAULT: begin
                     if (fault_ok) begin
                        sum_ctl.update = 1'b1;
                     end else begin
                        res_in.rc = RC_PARAM;
                     end
                  end
                  FN_CLEAR: begin
                     sum_ctl.clear = 1'b1;
                     valid_in      = '0;
                     used_in       = '0;
                  end
                  default: begin
                     res_in.rc = RC_PARAM;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Issue the next read while entries remain.
            if (!scan_end) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = scan_ff[SLOT_W-1:0];
               scan_in         = scan_ff + CNT_W'(1);
               pend_in         = 1'b1;
               pend_idx_in     = scan_ff[SLOT_W-1:0];
            end
            if (hit) begin
               state_in = ST_FINISH;
               pend_in  = 1'b0;
               if (cmd_func_ff == FN_FEED) begin
                  mem_req.wr_en         = 1'b1;
                  mem_req.wr_addr       = pend_idx_ff;
                  mem_req.wr_data       = mem_rdata;
                  mem_req.wr_data.feeds = mem_rdata.feeds + 32'd1;
               end else if (cmd_func_ff == FN_QUERY) begin
                  res_in.feeds = mem_rdata.feeds;
                  res_in.tmo   = mem_rdata.tmo;
               end else begin
                  // Re-registering a known id resets its entry.
                  mem_req.wr_en         = 1'b1;
                  mem_req.wr_addr       = pend_idx_ff;
                  mem_req.wr_data.id    = cmd_id_ff;
                  mem_req.wr_data.tmo   = cmd_tmo_ff;
                  mem_req.wr_data.feeds = 32'd0;
               end
            end else if (scan_end) begin
               state_in = ST_FINISH;
               if (cmd_func_ff == FN_REGISTER) begin
                  if (free_any) begin
                     mem_req.wr_en         = 1'b1;
                     mem_req.wr_addr       = free_idx;
                     mem_req.wr_data.id    = cmd_id_ff;
                     mem_req.wr_data.tmo   = cmd_tmo_ff;
                     mem_req.wr_data.feeds = 32'd0;
                     valid_in[free_idx]    = 1'b1;
                     used_in               = used_ff + CNT_W'(1);
                  end else begin
                     res_in.rc = RC_FULL;
                  end
               end else begin
                  res_in.rc = RC_NOT_FOUND;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         scan_ff       <= '0;
         pend_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
         used_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         pend_ff       <= pend_in;
         free_found_ff <= free_found_in;
         valid_ff      <= valid_in;
         used_ff       <= used_in;
      end
   end

   // Command and result payload.
   always_ff @(posedge clock) begin
      cmd_func_ff <= cmd_func_in;
      cmd_id_ff   <= cmd_id_in;
      cmd_tmo_ff  <= cmd_tmo_in;
      pend_idx_ff <= pend_idx_in;
      free_idx_ff <= free_idx_in;
      res_ff      <= res_in;
   end

   assign result     = res_ff;
   assign slots_used = used_ff;

   // The slot count always matches the number of valid entries.
   a_used_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == used_ff)
      else $error("slot count differs from valid bits");

   // The memory is written only while a command is scanning.
   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> state_ff == ST_SCAN)
      else $error("slot memory written outside a scan");

   // A taken word closes the input until its result is handed over.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after a word was taken");

endmodule

// ----- hdl/task_heartbeat_registry_unit.sv -----
// Top level of the task heartbeat registry: sequencer, slot memory, fault
// summary and the result register. Uses hbr_pkg and the hbr_* modules.
//
// One command word is processed at a time and each gives one result word.
// Fault reports, clear-all, rejected registers and unknown codes skip the scan;
// register, feed and query scan the slot memory one entry per cycle through its
// single read port, ending early when the id is found. The result register
// lets a new word be taken while the previous result is still stalled.
// Status fields show the state after the command; entry fields are nonzero
// only for a found query.
module task_heartbeat_registry_unit
   import hbr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic [31:0]        req_task_id,
   input  logic [31:0]        req_timeout_limit,
   input  logic [7:0]         req_fault_kind,
   input  logic [2:0]         req_fault_level,
   input  logic signed [31:0] req_err_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_result_code,
   output logic [31:0]        rsp_entry_feed_count,
   output logic [31:0]        rsp_entry_timeout,
   output logic [4:0]         rsp_registered_count,
   output logic [31:0]        rsp_faults_seen,
   output logic [1:0]         rsp_worst_level,
   output logic               rsp_fatal_flag,
   output logic [7:0]         rsp_latest_fault,
   output logic signed [31:0] rsp_latest_error
);

   logic             out_free;
   logic             done;
   res_type          result;
   logic [CNT_W-1:0] slots_used;
   sum_ctl_type      sum_ctl;
   mem_req_type      mem_req;
   slot_type         mem_rdata;
   fault_sum_type    fault_sum;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rc_ff;
   logic [31:0]        feeds_ff;
   logic [31:0]        tmo_ff;
   logic [4:0]         count_ff;
   fault_sum_type      sum_ff;

   hbr_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_task_id       (req_task_id),
      .req_timeout_limit (req_timeout_limit),
      .req_fault_kind    (req_fault_kind),
      .req_fault_level   (req_fault_level),
      .out_free          (out_free),
      .done              (done),
      .result            (result),
      .slots_used        (slots_used),
      .sum_ctl           (sum_ctl),
      .mem_req           (mem_req),
      .mem_rdata         (mem_rdata)
   );

   hbr_slot_ram u_slot_ram (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   hbr_fault_sum u_fault_sum (
      .clock       (clock),
      .reset       (reset),
      .sum_ctl     (sum_ctl),
      .fault_kind  (req_fault_kind),
      .fault_level (req_fault_level),
      .err_value   (req_err_value),
      .fault_sum   (fault_sum)
   );

   // The result register can take a new word when empty or being drained.
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded when the sequencer finishes a command.
   always_ff @(posedge clock) begin
      if (done) begin
         rc_ff    <= result.rc;
         feeds_ff <= result.feeds;
         tmo_ff   <= result.tmo;
         count_ff <= 5'(slots_used);
         sum_ff   <= fault_sum;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_code      = rc_ff;
   assign rsp_entry_feed_count = feeds_ff;
   assign rsp_entry_timeout    = tmo_ff;
   assign rsp_registered_count = count_ff;
   assign rsp_faults_seen      = sum_ff.total;
   assign rsp_worst_level      = sum_ff.peak;
   assign rsp_fatal_flag       = sum_ff.fatal;
   assign rsp_latest_fault     = sum_ff.kind;
   assign rsp_latest_error     = sum_ff.err;

endmodule

// ----- test/task_heartbeat_registry_unit_test.sv -----
// Self-checking testbench for task_heartbeat_registry_unit: directed and random
// command words with random idling on both channels, checked against a local predictor.
// Depends on hbr_pkg and the registry RTL only.
module task_heartbeat_registry_unit_test;
   import hbr_pkg::*;

   // Highest func code; codes above FN_CLEAR are unassigned.
   localparam logic [2:0] FN_TOP = 3'd7;
   localparam int POOL_SIZE    = 24;
   localparam int RANDOM_WORDS = 1600;
   localparam int LONG_HOLD    = 150;
   localparam int TAIL_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 800000;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] task_id;
      logic [31:0] timeout_limit;
      logic [7:0]  fault_kind;
      logic [2:0]  fault_level;
      logic [31:0] err_value;
   } command_type;

   typedef struct packed {
      logic [1:0]  rc;
      logic [31:0] feeds;
      logic [31:0] tmo;
      logic [4:0]  count;
      logic [31:0] faults;
      logic [1:0]  peak;
      logic        fatal;
      logic [7:0]  kind;
      logic [31:0] err;
   } status_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_func = '0;
   logic [31:0]        req_task_id = '0;
   logic [31:0]        req_timeout_limit = '0;
   logic [7:0]         req_fault_kind = '0;
   logic [2:0]         req_fault_level = '0;
   logic signed [31:0] req_err_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_result_code;
   logic [31:0]        rsp_entry_feed_count;
   logic [31:0]        rsp_entry_timeout;
   logic [4:0]         rsp_registered_count;
   logic [31:0]        rsp_faults_seen;
   logic [1:0]         rsp_worst_level;
   logic               rsp_fatal_flag;
   logic [7:0]         rsp_latest_fault;
   logic signed [31:0] rsp_latest_error;

   // Predicted registry contents.
   logic        slot_live [TASK_SLOTS];
   logic [31:0] slot_key [TASK_SLOTS];
   logic [31:0] slot_limit [TASK_SLOTS];
   logic [31:0] slot_beats [TASK_SLOTS];
   logic [4:0]  used_slots;
   logic [31:0] faults_logged;
   logic [1:0]  top_level;
   logic        fatal_latch;
   logic [7:0]  last_kind;
   logic [31:0] last_err;

   status_type  status_due [$];
   logic [31:0] id_pool [POOL_SIZE];
   int          mismatches = 0;
   int          results_checked = 0;
   int          func_tally [8];
   int          rc_tally [4];
   int          cycle_count = 0;
   bit          sender_idles = 1'b1;
   logic        receiver_idles = 1'b1;
   int          hold_order = 0;
   int          hold_served = 0;
   int          stall_left = 0;

   task_heartbeat_registry_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void wipe_registry();
      for (int i = 0; i < TASK_SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_key[i] = '0;
         slot_limit[i] = '0;
         slot_beats[i] = '0;
      end
      used_slots = '0;
      faults_logged = '0;
      top_level = '0;
      fatal_latch = 1'b0;
      last_kind = '0;
      last_err = '0;
   endfunction

   function automatic int find_slot(logic [31:0] id);
      int hit;
      hit = -1;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (slot_live[i] && slot_key[i] == id) hit = i;
      end
      return hit;
   endfunction

   // Applies one command word to the predicted registry and returns its status word.
   function automatic status_type registry_outcome(command_type c);
      status_type r;
      int hit;
      r = '0;
      r.rc = RC_OK;
      case (c.func)
         FN_REGISTER: begin
            if (c.task_id == '0 || c.timeout_limit == '0) begin
               r.rc = RC_PARAM;
            end else begin
               hit = find_slot(c.task_id);
               // A new id takes the lowest free slot.
               for (int i = 0; i < TASK_SLOTS; i++) begin
                  if (hit < 0 && !slot_live[i]) begin
                     hit = i;
                     used_slots = used_slots + 1'b1;
                  end
               end
               if (hit < 0) begin
                  r.rc = RC_FULL;
               end else begin
                  slot_beats[hit] = '0;
                  slot_key[hit] = c.task_id;
                  slot_limit[hit] = c.timeout_limit;
                  slot_live[hit] = 1'b1;
               end
            end
         end
         FN_FEED: begin
            hit = find_slot(c.task_id);
            if (hit < 0) r.rc = RC_NOT_FOUND;
            else slot_beats[hit] = slot_beats[hit] + 1;
         end
         FN_FAULT: begin
            if (c.fault_kind == '0 || c.fault_level == '0 || c.fault_level > LVL_FATAL) begin
               r.rc = RC_PARAM;
            end else begin
               faults_logged = faults_logged + 1;
               last_kind = c.fault_kind;
               last_err = c.err_value;
               if (c.fault_level[1:0] > top_level) top_level = c.fault_level[1:0];
               if (c.fault_level == LVL_FATAL) fatal_latch = 1'b1;
            end
         end
         FN_QUERY: begin
            hit = find_slot(c.task_id);
            if (hit < 0) begin
               r.rc = RC_NOT_FOUND;
            end else begin
               r.feeds = slot_beats[hit];
               r.tmo = slot_limit[hit];
            end
         end
         FN_CLEAR: wipe_registry();
         default: r.rc = RC_PARAM;
      endcase
      r.count = used_slots;
      r.faults = faults_logged;
      r.peak = top_level;
      r.fatal = fatal_latch;
      r.kind = last_kind;
      r.err = last_err;
      return r;
   endfunction

   function automatic command_type make_cmd(input logic [2:0] f, input logic [31:0] id,
                                             input logic [31:0] tmo, input logic [7:0] kind,
                                             input logic [2:0] lvl, input logic [31:0] err);
      command_type c;
      c.func = f;
      c.task_id = id;
      c.timeout_limit = tmo;
      c.fault_kind = kind;
      c.fault_level = lvl;
      c.err_value = err;
      return c;
   endfunction

   // Pool ids are nonzero and distinct through their low five bits.
   function automatic void refill_pool();
      for (int k = 0; k < POOL_SIZE; k++) begin
         id_pool[k] = ($urandom & 32'hFFFF_FFE0) | (k + 1);
      end
   endfunction

   // Random command word, ids mostly from the pool so that lookups hit.
   function automatic command_type random_cmd();
      command_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 32) c.func = FN_REGISTER;
      else if (pick < 58) c.func = FN_FEED;
      else if (pick < 78) c.func = FN_QUERY;
      else if (pick < 93) c.func = FN_FAULT;
      else if (pick < 94) c.func = FN_CLEAR;
      else c.func = 3'($urandom_range(FN_CLEAR + 1, FN_TOP));
      pick = $urandom_range(0, 99);
      if (pick < 80) c.task_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 90) c.task_id = $urandom;
      else if (pick < 95) c.task_id = '0;
      else c.task_id = '1;
      pick = $urandom_range(0, 99);
      if (pick < 5) c.timeout_limit = '0;
      else if (pick < 10) c.timeout_limit = '1;
      else c.timeout_limit = $urandom;
      c.fault_kind = ($urandom_range(0, 99) < 8) ? 8'd0 : 8'($urandom_range(1, 255));
      pick = $urandom_range(0, 99);
      if (pick < 8) c.fault_level = '0;
      else if (pick < 16) c.fault_level = 3'($urandom_range(4, 7));
      else if (pick < 56) c.fault_level = 3'd1;
      else if (pick < 86) c.fault_level = 3'd2;
      else c.fault_level = LVL_FATAL;
      c.err_value = $urandom;
      return c;
   endfunction

   // Offers one word after an optional gap and holds it until it is taken.
   task automatic send_word(input command_type c);
      int gap;
      gap = sender_idles ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= c.func;
      req_task_id <= c.task_id;
      req_timeout_limit <= c.timeout_limit;
      req_fault_kind <= c.fault_kind;
      req_fault_level <= c.fault_level;
      req_err_value <= c.err_value;
      do @(posedge clock); while (req_stall);
      status_due.push_back(registry_outcome(c));
      func_tally[c.func]++;
   endtask

   // Stops offering and waits until every predicted status word has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (status_due.size() != 0);
   endtask

   task automatic test_register_basics();
      send_word(make_cmd(FN_REGISTER, 32'd0, 32'd5, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_REGISTER, 32'd1, 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_REGISTER, '1, '1, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_FEED, '1, 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_FEED, '1, 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_QUERY, '1, 32'd0, 8'd0, 3'd0, 32'd0));
      // Registering a known id again reuses its slot and clears the feed count.
      send_word(make_cmd(FN_REGISTER, '1, 32'd1, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_QUERY, '1, 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_FEED, 32'd0, 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_QUERY, 32'h1234_5678, 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_REGISTER, 32'd1, 32'd1, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_QUERY, 32'd1, 32'd0, 8'd0, 3'd0, 32'd0));
      wait_drained();
   endtask

   task automatic test_fault_reports();
      // Kind zero, level zero and levels above fatal are all rejected.
      send_word(make_cmd(FN_FAULT, 32'd0, 32'd0, 8'd0, 3'd1, 32'd9));
      send_word(make_cmd(FN_FAULT, 32'd0, 32'd0, 8'd1, 3'd0, 32'd9));
      send_word(make_cmd(FN_FAULT, 32'd0, 32'd0, 8'd1, 3'd4, 32'd9));
      send_word(make_cmd(FN_FAULT, 32'd0, 32'd0, 8'hFF, 3'd7, 32'd9));
      send_word(make_cmd(FN_FAULT, 32'd0, 32'd0, 8'hFF, 3'd1, 32'h8000_0000));
      send_word(make_cmd(FN_FAULT, 32'd0, 32'd0, 8'h80, LVL_FATAL, 32'h7FFF_FFFF));
      send_word(make_cmd(FN_FAULT, 32'd0, 32'd0, 8'd7, 3'd2, '1));
      for (int f = FN_CLEAR + 1; f <= FN_TOP; f++) begin
         send_word(make_cmd(3'(f), 32'd1, 32'd1, 8'd1, 3'd1, 32'd0));
      end
      // Clear drops the table, the counters and the sticky fatal flag.
      send_word(make_cmd(FN_CLEAR, 32'd0, 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_QUERY, 32'd1, 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_FAULT, 32'd0, 32'd0, 8'd1, 3'd2, 32'd0));
      wait_drained();
   endtask

   task automatic test_table_full();
      refill_pool();
      send_word(make_cmd(FN_CLEAR, 32'd0, 32'd0, 8'd0, 3'd0, 32'd0));
      for (int k = 0; k < TASK_SLOTS; k++) begin
         send_word(make_cmd(FN_REGISTER, id_pool[k], $urandom_range(1, 32'hFFFF_FFFF),
                            8'd0, 3'd0, 32'd0));
      end
      // One more new id does not fit, but a known id still re-registers.
      send_word(make_cmd(FN_REGISTER, id_pool[TASK_SLOTS], 32'd10, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_REGISTER, id_pool[3], 32'd77, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_FEED, id_pool[3], 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_QUERY, id_pool[3], 32'd0, 8'd0, 3'd0, 32'd0));
      send_word(make_cmd(FN_QUERY, id_pool[TASK_SLOTS], 32'd0, 8'd0, 3'd0, 32'd0));
      wait_drained();
   endtask

   task automatic test_random_mix();
      refill_pool();
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // Every fourth stretch runs with no idling on either side.
         if (n % 200 == 0) begin
            sender_idles = ((n / 200) % 4 != 3);
            receiver_idles <= ((n / 200) % 4 != 3);
         end
         if (n % 400 == 399) refill_pool();
         send_word(random_cmd());
      end
      sender_idles = 1'b1;
      receiver_idles <= 1'b1;
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_backpressure();
      sender_idles = 1'b0;
      hold_order <= hold_order + 1;
      for (int n = 0; n < 24; n++) send_word(random_cmd());
      sender_idles = 1'b1;
      wait_drained();
   endtask

   // The sender pauses until every status word has come back.
   task automatic test_drain_pause();
      for (int round = 0; round < 4; round++) begin
         for (int n = 0; n < 8; n++) send_word(random_cmd());
         wait_drained();
      end
   endtask

   // Result stall: a requested long hold first, otherwise random gaps, or none while the receiver does not idle.
   always @(posedge clock) begin : stall_drive
      int gap;
      if (hold_order != hold_served) begin
         hold_served <= hold_order;
         stall_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (receiver_idles) begin
         gap = pick_gap();
         stall_left <= gap;
         rsp_stall <= (gap != 0);
      end else begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 50) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
         end
      end
   endtask

   // Each status word taken is compared with the oldest prediction.
   always @(posedge clock) begin : result_check
      status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            mismatches++;
            $display("%0t: status word arrived with nothing expected", $time);
         end else begin
            want = status_due.pop_front();
            check_field("result_code", want.rc, rsp_result_code);
            check_field("entry_feed_count", want.feeds, rsp_entry_feed_count);
            check_field("entry_timeout", want.tmo, rsp_entry_timeout);
            check_field("registered_count", want.count, rsp_registered_count);
            check_field("faults_seen", want.faults, rsp_faults_seen);
            check_field("worst_level", want.peak, rsp_worst_level);
            check_field("fatal_flag", want.fatal, rsp_fatal_flag);
            check_field("latest_fault", want.kind, rsp_latest_fault);
            check_field("latest_error", want.err, rsp_latest_error);
            rc_tally[rsp_result_code]++;
            results_checked++;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at cycle %0d with %0d status words outstanding.",
                  cycle_count, status_due.size());
         $display("task_heartbeat_registry_unit test failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 8; i++) func_tally[i] = 0;
      for (int i = 0; i < 4; i++) rc_tally[i] = 0;
      wipe_registry();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_register_basics();
      test_fault_reports();
      test_table_full();
      test_random_mix();
      test_backpressure();
      test_drain_pause();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (status_due.size() != 0) mismatches++;
      $display("Sent %0d register, %0d feed, %0d fault, %0d query, %0d clear words.",
               func_tally[FN_REGISTER], func_tally[FN_FEED], func_tally[FN_FAULT],
               func_tally[FN_QUERY], func_tally[FN_CLEAR]);
      $display("Checked %0d status words: %0d ok, %0d bad parameter, %0d full, %0d not found.",
               results_checked, rc_tally[RC_OK], rc_tally[RC_PARAM], rc_tally[RC_FULL],
               rc_tally[RC_NOT_FOUND]);
      if (mismatches == 0) begin
         $display("task_heartbeat_registry_unit test passed");
      end else begin
         $display("task_heartbeat_registry_unit test failed");
      end
      $finish;
   end

endmodule

// ----- task_heartbeat_registry_unit.f -----
hdl/hbr_pkg.sv
hdl/hbr_slot_ram.sv
hdl/hbr_fault_sum.sv
hdl/hbr_ctrl.sv
hdl/task_heartbeat_registry_unit.sv
test/task_heartbeat_registry_unit_test.sv
